// File: hdl/bgr_pkg.sv
// ----------------------------------------------------------------------------
// bgr_pkg: shared types, constants and functions of the bar graph renderer
// Holds window geometry, level mapping constants, the glyph table and the
// request/response bundle of the iterative divider.
// ----------------------------------------------------------------------------
`default_nettype none

package bgr_pkg;

  // Window and display geometry
  localparam int WINDOW   = 16;
  localparam int ROWS     = 4;

  // Field widths
  localparam int SAMPLE_W = 16;
  localparam int COUNT_W  = 16;
  localparam int COL_W    = 4;
  localparam int ROW_W    = 2;
  localparam int GLYPH_W  = 8;

  // Derived widths
  localparam int XW      = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SPAN_W  = $clog2(WINDOW + 1);
  localparam int KW      = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int DIFF_W  = SAMPLE_W + 1;

  // Level mapping: level = diff * (LEVEL_TOP - 1) / range + 1
  localparam int LEVEL_TOP = 32;
  localparam int QW        = $clog2(LEVEL_TOP);
  localparam int LVL_W     = QW + 1;
  localparam int NUM_W     = DIFF_W + QW;
  localparam int ROW_STEP  = 8;
  localparam int PART_W    = LVL_W + KW + 4;

  // Samples at or below this value are missing
  localparam logic signed [SAMPLE_W-1:0] MISS_LIMIT = -16'sd999;

  // Glyph codes
  localparam logic [GLYPH_W-1:0] GLYPH_FULL    = 8'd7;
  localparam logic [GLYPH_W-1:0] GLYPH_3QUART  = 8'd6;
  localparam logic [GLYPH_W-1:0] GLYPH_HALF    = 8'd5;
  localparam logic [GLYPH_W-1:0] GLYPH_QUART   = 8'd4;
  localparam logic [GLYPH_W-1:0] GLYPH_BLANK   = 8'd32;

  // Part thresholds
  localparam int PART_FULL   = 7;
  localparam int PART_3QUART = 5;
  localparam int PART_HALF   = 3;
  localparam int PART_QUART  = 1;

  // Divider request and response
  typedef struct packed {
    logic              start;
    logic [NUM_W-1:0]  num;
    logic [DIFF_W-1:0] den;
  } bgr_div_req_t;

  typedef struct packed {
    logic          done;
    logic [QW-1:0] quot;
  } bgr_div_rsp_t;

  // Map the part of a level that falls into one row to its glyph
  function automatic logic [GLYPH_W-1:0] glyph_for(input logic signed [PART_W-1:0] part);
    logic [GLYPH_W-1:0] g;
    if (part >= PART_W'(PART_FULL)) begin
      g = GLYPH_FULL;
    end else if (part >= PART_W'(PART_3QUART)) begin
      g = GLYPH_3QUART;
    end else if (part >= PART_W'(PART_HALF)) begin
      g = GLYPH_HALF;
    end else if (part >= PART_W'(PART_QUART)) begin
      g = GLYPH_QUART;
    end else begin
      g = GLYPH_BLANK;
    end
    return g;
  endfunction

endpackage

`default_nettype wire

// File: hdl/bar_graph_glyph_renderer.sv
// ----------------------------------------------------------------------------
// bar_graph_glyph_renderer: top level of the bar graph glyph renderer
// Shift window, range scan, per-column level mapping and glyph output.
// ----------------------------------------------------------------------------
// While idle the block takes one sample per cycle into a 16-entry window. A
// sample marked end_of_buffer is stored and then starts a frame, during which
// in_stall_o is high: the block scans the whole window for the range, fixes the
// bounds, then gives each column a setup step, a pass through the shared
// shift-subtract divider when it lies inside the valid span (none otherwise),
// and four glyph transfers, bottom row first, each held while out_stall_i is
// high. frame_done_o marks the last glyph of the frame.
// ----------------------------------------------------------------------------
`default_nettype none

module bar_graph_glyph_renderer (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // sample channel
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic signed [bgr_pkg::SAMPLE_W-1:0] sample_i,
  input  wire logic [bgr_pkg::COUNT_W-1:0]         valid_count_i,
  input  wire logic                                end_of_buffer_i,
  // glyph channel
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic [bgr_pkg::COL_W-1:0]                column_o,
  output logic [bgr_pkg::ROW_W-1:0]                row_o,
  output logic [bgr_pkg::GLYPH_W-1:0]              glyph_o,
  output logic                                     frame_done_o
);
  import bgr_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RANGE,
    ST_PREP,
    ST_DIV,
    ST_EMIT
  } state_e;

  state_e                     state_q;
  logic [XW-1:0]              x_q;
  logic [KW-1:0]              k_q;
  logic [SPAN_W-1:0]          span_q;
  logic                       found_q;
  logic signed [SAMPLE_W-1:0] lo_q;
  logic signed [DIFF_W-1:0]   hi_q;
  logic [DIFF_W-1:0]          den_q;
  logic [LVL_W-1:0]           level_q;

  logic                       in_xfer;
  logic                       out_xfer;
  logic signed [SAMPLE_W-1:0] rd_data;
  logic                       in_span;
  logic                       present;
  logic signed [DIFF_W-1:0]   vsel;
  logic signed [DIFF_W:0]     diff_full;
  logic [DIFF_W-1:0]          diff;
  logic [SPAN_W-1:0]          span_d;
  logic signed [DIFF_W:0]     range_full;
  logic signed [PART_W-1:0]   part;
  bgr_div_req_t               div_req;
  bgr_div_rsp_t               div_rsp;

  assign in_xfer  = in_valid_i && !in_stall_o;
  assign out_xfer = out_valid_o && !out_stall_i;

  // Sample window
  bgr_window u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_xfer),
    .push_data_i (sample_i),
    .rd_idx_i    (x_q),
    .rd_data_o   (rd_data)
  );

  // Shared divider
  bgr_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Column selection, clamp and numerator of the level mapping
  always_comb begin
    in_span = SPAN_W'(x_q) >= (SPAN_W'(WINDOW) - span_q);
    present = rd_data > MISS_LIMIT;
    vsel    = present ? DIFF_W'(rd_data) : DIFF_W'(lo_q);
    if (vsel < DIFF_W'(lo_q)) begin
      vsel = DIFF_W'(lo_q);
    end
    if (vsel > hi_q) begin
      vsel = hi_q;
    end
    diff_full = (DIFF_W+1)'(vsel) - (DIFF_W+1)'(lo_q);
    diff      = diff_full[DIFF_W-1:0];
    div_req.start = (state_q == ST_PREP) && in_span;
    div_req.num   = (NUM_W'(diff) << QW) - NUM_W'(diff);
    div_req.den   = den_q;
  end

  // Clamp the span count and form the final range
  always_comb begin
    span_d     = (valid_count_i > COUNT_W'(WINDOW)) ? SPAN_W'(WINDOW)
                                                    : valid_count_i[SPAN_W-1:0];
    range_full = (DIFF_W+1)'(hi_q) - (DIFF_W+1)'(lo_q);
  end

  // Sequencer and range registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      x_q     <= '0;
      k_q     <= '0;
      span_q  <= '0;
      found_q <= 1'b0;
      lo_q    <= '0;
      hi_q    <= '0;
      den_q   <= '0;
      level_q <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_xfer && end_of_buffer_i) begin
            span_q  <= span_d;
            found_q <= 1'b0;
            x_q     <= '0;
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (in_span && present) begin
            found_q <= 1'b1;
            if (!found_q || rd_data < lo_q) begin
              lo_q <= rd_data;
            end
            if (!found_q || DIFF_W'(rd_data) > hi_q) begin
              hi_q <= DIFF_W'(rd_data);
            end
          end
          if (x_q == XW'(WINDOW - 1)) begin
            state_q <= ST_RANGE;
          end else begin
            x_q <= x_q + 1'b1;
          end
        end
        ST_RANGE: begin
          if (!found_q) begin
            lo_q  <= '0;
            hi_q  <= DIFF_W'(1);
            den_q <= DIFF_W'(1);
          end else if (hi_q == DIFF_W'(lo_q)) begin
            hi_q  <= DIFF_W'(lo_q) + 1'b1;
            den_q <= DIFF_W'(1);
          end else begin
            den_q <= range_full[DIFF_W-1:0];
          end
          x_q     <= '0;
          state_q <= ST_PREP;
        end
        ST_PREP: begin
          k_q <= '0;
          if (in_span) begin
            state_q <= ST_DIV;
          end else begin
            level_q <= '0;
            state_q <= ST_EMIT;
          end
        end
        ST_DIV: begin
          if (div_rsp.done) begin
            level_q <= LVL_W'(div_rsp.quot) + 1'b1;
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_xfer) begin
            if (k_q == KW'(ROWS - 1)) begin
              if (x_q == XW'(WINDOW - 1)) begin
                state_q <= ST_IDLE;
              end else begin
                x_q     <= x_q + 1'b1;
                state_q <= ST_PREP;
              end
            end else begin
              k_q <= k_q + 1'b1;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Glyph for the current row of the current column
  always_comb begin
    part = PART_W'(level_q) - PART_W'(ROW_STEP) * PART_W'(k_q);
  end

  // Drive the ports
  assign in_stall_o   = (state_q != ST_IDLE);
  assign out_valid_o  = (state_q == ST_EMIT);
  assign column_o     = COL_W'(x_q);
  assign row_o        = ROW_W'(KW'(ROWS - 1) - k_q);
  assign glyph_o      = glyph_for(part);
  assign frame_done_o = (x_q == XW'(WINDOW - 1)) && (k_q == KW'(ROWS - 1));

endmodule

`default_nettype wire

// File: hdl/bgr_window.sv
// ----------------------------------------------------------------------------
// bgr_window: sample shift window
// Keeps the last WINDOW samples, oldest at index 0, with one read port.
// ----------------------------------------------------------------------------
`default_nettype none

module bgr_window (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 push_i,
  input  wire logic signed [bgr_pkg::SAMPLE_W-1:0]  push_data_i,
  input  wire logic [bgr_pkg::XW-1:0]               rd_idx_i,
  output logic signed [bgr_pkg::SAMPLE_W-1:0]       rd_data_o
);
  import bgr_pkg::*;

  logic signed [SAMPLE_W-1:0] win_q [WINDOW];

  // Shift in a new sample at the young end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WINDOW; i++) begin
        win_q[i] <= '0;
      end
    end else if (push_i) begin
      for (int i = 0; i < WINDOW - 1; i++) begin
        win_q[i] <= win_q[i+1];
      end
      win_q[WINDOW-1] <= push_data_i;
    end
  end

  // Select one entry
  assign rd_data_o = win_q[rd_idx_i];

endmodule

`default_nettype wire

// File: hdl/bgr_div.sv
// ----------------------------------------------------------------------------
// bgr_div: iterative restoring divider
// Produces a QW-bit quotient, one compare and subtract per cycle.
// The quotient must fit in QW bits.
// ----------------------------------------------------------------------------
`default_nettype none

module bgr_div (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire bgr_pkg::bgr_div_req_t req_i,
  output bgr_pkg::bgr_div_rsp_t      rsp_o
);
  import bgr_pkg::*;

  localparam int SW = (QW > 1) ? $clog2(QW) : 1;
  localparam int CW = NUM_W + QW;

  logic              busy_q;
  logic              done_q;
  logic [SW-1:0]     step_q;
  logic [NUM_W-1:0]  rem_q;
  logic [DIFF_W-1:0] den_q;
  logic [QW-1:0]     quot_q;

  logic [CW-1:0]     trial;
  logic [CW-1:0]     shifted;
  logic              fits;

  // Compare the remainder against the shifted divisor
  always_comb begin
    shifted = CW'(den_q) << step_q;
    fits    = CW'(rem_q) >= shifted;
    trial   = CW'(rem_q) - shifted;
  end

  // Advance one quotient bit per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        step_q <= SW'(QW - 1);
      end else if (busy_q) begin
        if (step_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          step_q <= step_q - 1'b1;
        end
      end
    end
  end

  // Remainder and quotient datapath
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q  <= req_i.num;
      den_q  <= req_i.den;
      quot_q <= '0;
    end else if (busy_q && fits) begin
      rem_q          <= trial[NUM_W-1:0];
      quot_q[step_q] <= 1'b1;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

`default_nettype wire

// File: tb/bgr_glyph_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bgr_glyph_checker: glyph stream checker for the bar graph renderer
// Watches the sample and glyph channels, keeps its own copy of the sample
// window, works out the glyphs of each frame and compares every glyph
// transfer field by field with the oldest glyph still expected.
// ----------------------------------------------------------------------------
module bgr_glyph_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // sample channel
  input  logic                                in_valid_i,
  input  logic                                in_stall_i,
  input  logic signed [bgr_pkg::SAMPLE_W-1:0] sample_i,
  input  logic [bgr_pkg::COUNT_W-1:0]         valid_count_i,
  input  logic                                end_of_buffer_i,
  // glyph channel
  input  logic                                out_valid_i,
  input  logic                                out_stall_i,
  input  logic [bgr_pkg::COL_W-1:0]           column_i,
  input  logic [bgr_pkg::ROW_W-1:0]           row_i,
  input  logic [bgr_pkg::GLYPH_W-1:0]         glyph_i,
  input  logic                                frame_done_i,
  // status
  output int                                  fail_count_o,
  output int                                  pending_o,
  output int                                  glyphs_checked_o,
  output int                                  frames_o
);

  localparam int MissFloor = int'(bgr_pkg::MISS_LIMIT);

  typedef struct {
    logic [bgr_pkg::COL_W-1:0]   column;
    logic [bgr_pkg::ROW_W-1:0]   row;
    logic [bgr_pkg::GLYPH_W-1:0] glyph;
    logic                        frame_done;
  } glyph_cell_t;

  logic signed [bgr_pkg::SAMPLE_W-1:0] history [bgr_pkg::WINDOW];
  glyph_cell_t                         expected_glyphs [$];
  int                                  mismatches = 0;
  int                                  glyphs_checked = 0;
  int                                  frames = 0;

  // Print one line per mismatch and count it
  task automatic report_mismatch(input string what);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  // Glyph for the part of a level that falls into one row cell
  function automatic logic [bgr_pkg::GLYPH_W-1:0] cell_glyph(input int part);
    if (part >= bgr_pkg::PART_FULL) return bgr_pkg::GLYPH_FULL;
    if (part >= bgr_pkg::PART_3QUART) return bgr_pkg::GLYPH_3QUART;
    if (part >= bgr_pkg::PART_HALF) return bgr_pkg::GLYPH_HALF;
    if (part >= bgr_pkg::PART_QUART) return bgr_pkg::GLYPH_QUART;
    return bgr_pkg::GLYPH_BLANK;
  endfunction

  // Shift a sample in; on the last sample of a buffer queue the whole frame
  task automatic take_sample(input logic signed [bgr_pkg::SAMPLE_W-1:0] s,
                             input logic [bgr_pkg::COUNT_W-1:0] cnt,
                             input logic last);
    int          span, lo, hi, v, level, x, k;
    bit          found;
    glyph_cell_t entry;
    for (x = 0; x < bgr_pkg::WINDOW - 1; x++) history[x] = history[x + 1];
    history[bgr_pkg::WINDOW - 1] = s;
    if (!last) return;
    frames++;
    span = (cnt > bgr_pkg::WINDOW) ? bgr_pkg::WINDOW : int'(cnt);

    // Range over the valid span, skipping missing samples
    found = 1'b0;
    lo = 0;
    hi = 0;
    for (x = bgr_pkg::WINDOW - span; x < bgr_pkg::WINDOW; x++) begin
      v = history[x];
      if (v > MissFloor) begin
        if (!found || v < lo) lo = v;
        if (!found || v > hi) hi = v;
        found = 1'b1;
      end
    end
    if (!found) begin
      lo = 0;
      hi = 1;
    end
    if (hi == lo) hi = lo + 1;

    // Level per column, then one glyph per row from the bottom up
    for (x = 0; x < bgr_pkg::WINDOW; x++) begin
      if (x < bgr_pkg::WINDOW - span) begin
        level = 0;
      end else begin
        v = history[x];
        if (v <= MissFloor) v = lo;
        if (v < lo) v = lo;
        if (v > hi) v = hi;
        level = (v - lo) * (bgr_pkg::LEVEL_TOP - 1) / (hi - lo) + 1;
      end
      for (k = 0; k < bgr_pkg::ROWS; k++) begin
        entry.column     = x[bgr_pkg::COL_W-1:0];
        entry.row        = bgr_pkg::ROW_W'(bgr_pkg::ROWS - 1 - k);
        entry.glyph      = cell_glyph(level - k * bgr_pkg::ROW_STEP);
        entry.frame_done = (x == bgr_pkg::WINDOW - 1) && (k == bgr_pkg::ROWS - 1);
        expected_glyphs.push_back(entry);
      end
    end
  endtask

  // Compare one glyph transfer with the oldest expected glyph
  task automatic check_glyph();
    glyph_cell_t want;
    if (expected_glyphs.size() == 0) begin
      report_mismatch($sformatf("unexpected glyph col %0d row %0d code %0d done %0b",
                                column_i, row_i, glyph_i, frame_done_i));
      return;
    end
    want = expected_glyphs.pop_front();
    glyphs_checked++;
    if (column_i !== want.column)
      report_mismatch($sformatf("column got %0d want %0d", column_i, want.column));
    if (row_i !== want.row)
      report_mismatch($sformatf("col %0d row got %0d want %0d", want.column, row_i, want.row));
    if (glyph_i !== want.glyph)
      report_mismatch($sformatf("col %0d row %0d glyph got %0d want %0d",
                                want.column, want.row, glyph_i, want.glyph));
    if (frame_done_i !== want.frame_done)
      report_mismatch($sformatf("col %0d row %0d frame_done got %0b want %0b",
                                want.column, want.row, frame_done_i, want.frame_done));
  endtask

  // Watch both channels; glyphs are checked before a new sample is taken
  always @(posedge clk_i or negedge rst_ni) begin : watch
    int idx;
    if (!rst_ni) begin
      for (idx = 0; idx < bgr_pkg::WINDOW; idx++) history[idx] = '0;
      expected_glyphs.delete();
    end else begin
      if (out_valid_i && !out_stall_i) check_glyph();
      if (in_valid_i && !in_stall_i) take_sample(sample_i, valid_count_i, end_of_buffer_i);
    end
    pending_o        <= expected_glyphs.size();
    fail_count_o     <= mismatches;
    glyphs_checked_o <= glyphs_checked;
    frames_o         <= frames;
  end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: regression for the bar graph glyph renderer
// Feeds directed and random sample buffers with random gaps on the sample
// side and random stalls on the glyph side; the checker predicts and
// compares every glyph and the verdict is given here.
// ----------------------------------------------------------------------------
module testbench;

  localparam int RandomItems = 430;
  localparam int QuietTail   = 60;
  localparam int CycleLimit  = 2000000;

  logic                                clk_i;
  logic                                rst_n = 1'b0;
  logic                                in_valid = 1'b0;
  logic signed [bgr_pkg::SAMPLE_W-1:0] sample = '0;
  logic [bgr_pkg::COUNT_W-1:0]         valid_count = '0;
  logic                                end_of_buffer = 1'b0;
  logic                                out_stall = 1'b0;
  logic                                in_stall;
  logic                                out_valid;
  logic [bgr_pkg::COL_W-1:0]           column;
  logic [bgr_pkg::ROW_W-1:0]           row;
  logic [bgr_pkg::GLYPH_W-1:0]         glyph;
  logic                                frame_done;

  int fail_count;
  int pending;
  int glyphs_checked;
  int frames;
  int idle_pct = 0;
  int stall_left = 0;
  int items_sent = 0;
  int cycle_count = 0;

  bar_graph_glyph_renderer dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .sample_i       (sample),
    .valid_count_i  (valid_count),
    .end_of_buffer_i(end_of_buffer),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .column_o       (column),
    .row_o          (row),
    .glyph_o        (glyph),
    .frame_done_o   (frame_done)
  );

  bgr_glyph_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .sample_i        (sample),
    .valid_count_i   (valid_count),
    .end_of_buffer_i (end_of_buffer),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .column_i        (column),
    .row_i           (row),
    .glyph_i         (glyph),
    .frame_done_i    (frame_done),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .glyphs_checked_o(glyphs_checked),
    .frames_o        (frames)
  );

  // 2 ns clock
  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // Bound the run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Timeout after %0d cycles, %0d glyphs still expected", cycle_count, pending);
      $display("Regression FAIL");
      $finish;
    end
  end

  // Stall the glyph side in random bursts
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (rst_n && idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      stall_left = $urandom_range(0, 3);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Present one sample and hold it until the transfer; returns at a falling edge
  task automatic send_sample(input logic signed [bgr_pkg::SAMPLE_W-1:0] s,
                             input logic [bgr_pkg::COUNT_W-1:0] cnt,
                             input logic last);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    in_valid      <= 1'b1;
    sample        <= s;
    valid_count   <= cnt;
    end_of_buffer <= last;
    do @(posedge clk_i); while (in_stall);
    items_sent++;
    @(negedge clk_i);
  endtask

  // Random sample: missing codes, extremes, or a value near the buffer's base
  function automatic logic signed [bgr_pkg::SAMPLE_W-1:0] pick_sample(input int base,
                                                                      input int spread);
    int t;
    case ($urandom_range(0, 11))
      0: t = -999;
      1: t = -int'($urandom_range(1000, 32768));
      2: t = -998;
      3: t = int'($urandom_range(0, 65535)) - 32768;
      4: t = ($urandom_range(0, 1) != 0) ? 32767 : -32768;
      default: begin
        t = base + int'($urandom_range(0, spread));
        if (t > 32767) t = 32767;
      end
    endcase
    return t[bgr_pkg::SAMPLE_W-1:0];
  endfunction

  // Count on the last sample: mostly inside the window, sometimes beyond it
  function automatic logic [bgr_pkg::COUNT_W-1:0] pick_count();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return bgr_pkg::COUNT_W'($urandom_range(bgr_pkg::WINDOW + 1, 65535));
      2: return bgr_pkg::COUNT_W'(bgr_pkg::WINDOW);
      default: return bgr_pkg::COUNT_W'($urandom_range(1, bgr_pkg::WINDOW));
    endcase
  endfunction

  initial begin
    int base, spread, fill, j, total;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_n <= 1'b1;
    @(negedge clk_i);

    // Directed: frame on a window still holding reset zeros
    idle_pct = 20;
    send_sample(100, 16, 1'b1);
    // Extremes, missing boundary, count above the window
    send_sample(-32768, 0, 1'b0);
    send_sample(32767, 0, 1'b0);
    send_sample(-1, 0, 1'b0);
    send_sample(-999, 0, 1'b0);
    send_sample(-998, 0, 1'b0);
    send_sample(0, 16'hffff, 1'b1);
    // No valid sample in the span
    send_sample(-999, 1, 1'b1);
    // Empty span: every column blank
    send_sample(5, 0, 1'b1);
    // Equal bounds
    send_sample(42, 0, 1'b0);
    send_sample(42, 0, 1'b0);
    send_sample(42, 0, 1'b0);
    send_sample(42, 4, 1'b1);
    // Missing samples drawn at the minimum, count just above the window
    send_sample(-1000, 17, 1'b1);
    send_sample(-5, 0, 1'b0);
    send_sample(7, 0, 1'b0);
    send_sample(-999, 0, 1'b0);
    send_sample(12, 5, 1'b1);

    // Random buffers; counts on non-last samples are noise the block ignores
    total = items_sent + RandomItems;
    while (items_sent < total) begin
      case ($urandom_range(0, 3))
        0: idle_pct = 0;
        1: idle_pct = 15;
        default: idle_pct = 40;
      endcase
      if (items_sent >= total - QuietTail) idle_pct = 0;
      base = int'($urandom_range(0, 4000)) - 2000;
      case ($urandom_range(0, 3))
        0: spread = 0;
        1: spread = 3;
        2: spread = 200;
        default: spread = 65535;
      endcase
      fill = $urandom_range(0, 18);
      for (j = 0; j < fill; j++)
        send_sample(pick_sample(base, spread),
                    bgr_pkg::COUNT_W'($urandom_range(0, 65535)), 1'b0);
      send_sample(pick_sample(base, spread), pick_count(), 1'b1);
    end
    in_valid <= 1'b0;

    // Drain the remaining glyphs, then allow a quiet tail
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    @(negedge clk_i);

    $display("Fed %0d samples forming %0d frames under random gaps and stalls",
             items_sent, frames);
    $display("Checked %0d glyph transfers, %0d mismatches", glyphs_checked, fail_count);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
